// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the inverse decryption round block.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/iaesdr_pkg.sv =====
// Package for the inverse decryption round block: AES S-box, GF(2^8) helpers,
// MixColumns on one column and register decode codes. Depends on nothing.
package iaesdr_pkg;

	localparam int BLOCK_W = 128;
	localparam int WORD_W  = 64;
	localparam int ADDR_W  = 4;

	// Register select: the two 64-bit key halves lie at byte addresses 0 and 8.
	typedef enum logic [0:0] {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} cfg_reg_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] sub_byte(input logic [7:0] b);
		return SBOX[b];
	endfunction

	// Multiply by two modulo the AES polynomial 0x11b.
	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// MixColumns on one column; row r sits in bits 8r+7..8r.
	function automatic logic [31:0] mix_column(input logic [31:0] col);
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		a0 = col[7:0];
		a1 = col[15:8];
		a2 = col[23:16];
		a3 = col[31:24];
		d0 = xtime(a0);
		d1 = xtime(a1);
		d2 = xtime(a2);
		d3 = xtime(a3);
		return {d0 ^ a0 ^ a1 ^ a2 ^ d3,
			a0 ^ a1 ^ d2 ^ d3 ^ a3,
			a0 ^ d1 ^ d2 ^ a2 ^ a3,
			d0 ^ d1 ^ a1 ^ a2 ^ a3};
	endfunction

endpackage

// ===== sv/inverse_aes_decrypt_round.sv =====
// An accepted input transaction reaches the master side through three registered stages.
// Throughput: one 128-bit block per cycle while m_axis_tready allows; the stages (key XOR, MixColumns,
// ShiftRows with S-box lookup) each hold one block and advance independently.
// Reset (arst_n low, asynchronous) clears the stage valid bits and both key registers.
// Top level of the inverse decryption round; uses iaesdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module inverse_aes_decrypt_round (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB-style configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [iaesdr_pkg::ADDR_W-1:0]  paddr,
	input  logic [iaesdr_pkg::WORD_W-1:0]  pwdata,
	output logic [iaesdr_pkg::WORD_W-1:0]  prdata,
	output logic                           pready,
	// Slave side
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// s_axis_tdata: block_low [63:0], block_high [127:64]
	input  logic [iaesdr_pkg::BLOCK_W-1:0] s_axis_tdata,
	// Master side
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// m_axis_tdata: preimage_low [63:0], preimage_high [127:64]
	output logic [iaesdr_pkg::BLOCK_W-1:0] m_axis_tdata
);
	import iaesdr_pkg::*;

	// Round key, written by the configuration port while no transaction is in flight (user rule, unchecked).
	logic [WORD_W-1:0]  key_low_q;
	logic [WORD_W-1:0]  key_high_q;
	logic               cfg_wr;
	cfg_reg_t           cfg_sel;

	// Pipeline stages: valid bit and payload per stage.
	logic               valid_s1, valid_s2, valid_s3;
	logic [BLOCK_W-1:0] data_s1, data_s2, data_s3;
	logic               ready_s1, ready_s2, ready_s3;
	logic [BLOCK_W-1:0] mix_d, shift_sub_d;

	// The register select is the address bit above the byte offset within a 64-bit word.
	assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_KEY_LOW:  key_low_q  <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_KEY_LOW:  prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			default:      prdata = '0;
		endcase
	end

	// A stage may load when it is empty or when the stage after it is moving on,
	// so bubbles are squeezed out; the ready path is combinational from m_axis_tready back to s_axis_tready.
	assign ready_s3      = !valid_s3 || m_axis_tready;
	assign ready_s2      = !valid_s2 || ready_s3;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	// MixColumns on the four columns held in stage one.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			mix_d[32*c +: 32] = mix_column(data_s1[32*c +: 32]);
		end
	end

	// ShiftRows then SubBytes: byte r of column c comes from row r of column (c + r) mod 4.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				shift_sub_d[8*(r + 4*c) +: 8] =
					sub_byte(data_s2[8*(r + 4*((c + r) % 4)) +: 8]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Payload registers need no reset; they load only when their stage advances.
	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata ^ {key_high_q, key_low_q};
		end
		if (ready_s2 && valid_s1) begin
			data_s2 <= mix_d;
		end
		if (ready_s3 && valid_s2) begin
			data_s3 <= shift_sub_d;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = data_s3;

	// An accepted transaction always occupies stage one in the following cycle.
	`ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, valid_s1,
		"accepted transaction did not reach stage one")
	// A block blocked in stage two keeps both its valid bit and its payload.
	`ASSERT_NEXT(a_s2_holds, valid_s2 && !ready_s3, valid_s2 && $stable(data_s2),
		"stage two lost or changed a stalled block")
	// Stage one handing on means stage two is full next cycle.
	`ASSERT_NEXT(a_s1_to_s2, valid_s1 && ready_s2, valid_s2,
		"block from stage one was dropped")
	// The slave side can only be blocked when every stage is full.
	`ASSERT_SAME(a_full_when_blocked, !s_axis_tready, valid_s1 && valid_s2 && valid_s3,
		"input stalled with an empty stage")

endmodule
